FILE: sv/cnc_pkg.sv
// ----------------------------------------------------------------------------
// cnc_pkg
// Shared codes, types and conversion functions of the checked numeric
// coercion block.
// ----------------------------------------------------------------------------
package cnc_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned KindW = 2;
  localparam int unsigned DataW = 64;

  localparam logic [CmdW-1:0] CMD_I64 = 3'd0;
  localparam logic [CmdW-1:0] CMD_U64 = 3'd1;
  localparam logic [CmdW-1:0] CMD_I32 = 3'd2;
  localparam logic [CmdW-1:0] CMD_U32 = 3'd3;
  localparam logic [CmdW-1:0] CMD_DBL = 3'd4;
  localparam logic [CmdW-1:0] CMD_FLT = 3'd5;

  localparam logic [KindW-1:0] KIND_I64 = 2'd0;
  localparam logic [KindW-1:0] KIND_U64 = 2'd1;
  localparam logic [KindW-1:0] KIND_DBL = 2'd2;
  localparam logic [KindW-1:0] KIND_NON = 2'd3;

  localparam logic [63:0] EXACT_LIMIT    = 64'h0020_0000_0000_0000;
  localparam logic [62:0] FLT_MAX_DBL    = 63'h47EF_FFFF_E000_0000;
  localparam logic [31:0] FLT_QNAN       = 32'h7FC0_0000;
  localparam logic [10:0] DBL_BIAS       = 11'd1023;
  localparam logic [10:0] DBL_INT_TOP    = 11'd1086;
  localparam logic [10:0] DBL_EXP_MAX    = 11'h7FF;
  localparam logic [10:0] FLT_NORM_MIN_E = 11'd897;

  typedef struct packed {
    logic        ok;
    logic        neg;
    logic [63:0] mag;
  } int_conv_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] bits;
  } flt_conv_t;

  // sign-magnitude integer to double, round to nearest even
  function automatic logic [63:0] int_to_double(input logic neg, input logic [63:0] mag);
    logic [6:0]  lz;
    logic [63:0] sh;
    logic [10:0] ex;
    logic        up;
    logic [62:0] body;
    lz = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) lz = 7'(63 - i);
    end
    sh   = mag << lz;
    ex   = 11'(DBL_INT_TOP - 11'(lz));
    up   = sh[10] && ((|sh[9:0]) || sh[11]);
    body = {ex, sh[62:11]} + 63'(up);
    int_to_double = (mag == 64'd0) ? 64'd0 : {neg, body};
  endfunction

  // double to integer magnitude, fails on fraction, nan, inf or >= 2^64
  function automatic int_conv_t double_to_int(input logic [63:0] d);
    logic [10:0]  e;
    logic [52:0]  sig;
    logic [127:0] t;
    int_conv_t    r;
    e       = d[62:52];
    sig     = {1'b1, d[51:0]};
    r.neg   = d[63];
    r.mag   = 64'd0;
    r.ok    = 1'b0;
    t       = {75'd0, sig} << 6'(e - DBL_BIAS);
    if (e == 11'd0) begin
      r.ok = (d[51:0] == 52'd0);
    end else if (e >= DBL_BIAS && e <= DBL_INT_TOP) begin
      r.ok  = (t[51:0] == 52'd0);
      r.mag = t[115:52];
    end
    double_to_int = r;
  endfunction

  // double to single, round to nearest even, fails on finite values above the largest float
  function automatic flt_conv_t double_to_float(input logic [63:0] d);
    logic [10:0]  e;
    logic [10:0]  e_eff;
    logic [52:0]  sig;
    logic [9:0]   sa;
    logic [116:0] wide;
    logic         up;
    logic [30:0]  body;
    flt_conv_t    r;
    e     = d[62:52];
    e_eff = (e == 11'd0) ? 11'd1 : e;
    sig   = {e != 11'd0, d[51:0]};
    sa    = 10'(11'd926 - e_eff);
    if (sa > 10'd63) sa = 10'd63;
    wide  = {sig, 64'd0} >> sa;
    r.ok  = 1'b1;
    if (e == DBL_EXP_MAX && d[51:0] != 52'd0) begin
      r.bits = FLT_QNAN;
    end else if (d[62:0] > FLT_MAX_DBL) begin
      r.ok   = (e == DBL_EXP_MAX);
      r.bits = {d[63], 8'hFF, 23'd0};
    end else if (e >= FLT_NORM_MIN_E) begin
      up     = d[28] && ((|d[27:0]) || d[29]);
      body   = {8'(e - 11'd896), d[51:29]} + 31'(up);
      r.bits = {d[63], body};
    end else begin
      up     = wide[63] && ((|wide[62:0]) || wide[64]);
      body   = {8'd0, wide[86:64]} + 31'(up);
      r.bits = {d[63], body};
    end
    double_to_float = r;
  endfunction

endpackage

FILE: sv/cnc_if.sv
// ----------------------------------------------------------------------------
// cnc_req_if / cnc_rsp_if
// Valid/ready channels carrying conversion requests and results.
// ----------------------------------------------------------------------------
interface cnc_req_if;
  logic                          valid;
  logic                          ready;
  logic [cnc_pkg::CmdW-1:0]      cmd;
  logic [cnc_pkg::KindW-1:0]     value_kind;
  logic [cnc_pkg::DataW-1:0]     payload;
  modport source (output valid, cmd, value_kind, payload, input ready);
  modport sink   (input valid, cmd, value_kind, payload, output ready);
endinterface

interface cnc_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [cnc_pkg::DataW-1:0] result_bits;
  modport source (output valid, ok, result_bits, input ready);
  modport sink   (input valid, ok, result_bits, output ready);
endinterface

FILE: sv/cnc_conv.sv
// ----------------------------------------------------------------------------
// cnc_conv
// Combinational checked conversion of one stored number to a target type.
// ----------------------------------------------------------------------------
module cnc_conv (
  input  logic [cnc_pkg::CmdW-1:0]  cmd,
  input  logic [cnc_pkg::KindW-1:0] value_kind,
  input  logic [cnc_pkg::DataW-1:0] payload,
  output logic                      ok,
  output logic [cnc_pkg::DataW-1:0] result_bits
);

  cnc_pkg::int_conv_t dint;
  cnc_pkg::flt_conv_t flt;
  logic        i64_ok, u64_ok, dbl_ok;
  logic [63:0] i64_val, u64_val;
  logic        src_neg;
  logic [63:0] src_mag;
  logic [63:0] src_dbl;
  logic        ok_raw;
  logic [63:0] res_raw;

  assign dint = cnc_pkg::double_to_int(payload);

  always_comb begin
    i64_ok  = 1'b0;
    i64_val = payload;
    u64_ok  = 1'b0;
    u64_val = payload;
    case (value_kind)
      cnc_pkg::KIND_I64: begin
        i64_ok = 1'b1;
        u64_ok = !payload[63];
      end
      cnc_pkg::KIND_U64: begin
        i64_ok = !payload[63];
        u64_ok = 1'b1;
      end
      cnc_pkg::KIND_DBL: begin
        i64_ok  = dint.ok && (dint.neg ? (dint.mag <= 64'h8000_0000_0000_0000)
                                       : !dint.mag[63]);
        i64_val = dint.neg ? (64'd0 - dint.mag) : dint.mag;
        u64_ok  = dint.ok && (!dint.neg || dint.mag == 64'd0);
        u64_val = dint.mag;
      end
      default: begin
        i64_ok = 1'b0;
        u64_ok = 1'b0;
      end
    endcase
  end

  // integer source as sign and magnitude
  assign src_neg = (value_kind == cnc_pkg::KIND_I64) && payload[63];
  assign src_mag = src_neg ? (64'd0 - payload) : payload;
  assign src_dbl = (value_kind == cnc_pkg::KIND_DBL) ? payload
                 : cnc_pkg::int_to_double(src_neg, src_mag);
  assign dbl_ok  = (value_kind == cnc_pkg::KIND_DBL)
                || ((value_kind == cnc_pkg::KIND_I64 || value_kind == cnc_pkg::KIND_U64)
                    && src_mag <= cnc_pkg::EXACT_LIMIT);
  assign flt     = cnc_pkg::double_to_float(src_dbl);

  always_comb begin
    ok_raw  = 1'b0;
    res_raw = 64'd0;
    case (cmd)
      cnc_pkg::CMD_I64: begin
        ok_raw  = i64_ok;
        res_raw = i64_val;
      end
      cnc_pkg::CMD_U64: begin
        ok_raw  = u64_ok;
        res_raw = u64_val;
      end
      cnc_pkg::CMD_I32: begin
        ok_raw  = i64_ok && ((i64_val[63:31] == 33'd0) || (&i64_val[63:31]));
        res_raw = {32'd0, i64_val[31:0]};
      end
      cnc_pkg::CMD_U32: begin
        ok_raw  = u64_ok && (u64_val[63:32] == 32'd0);
        res_raw = u64_val;
      end
      cnc_pkg::CMD_DBL: begin
        ok_raw  = dbl_ok;
        res_raw = src_dbl;
      end
      cnc_pkg::CMD_FLT: begin
        ok_raw  = flt.ok && (value_kind != cnc_pkg::KIND_NON);
        res_raw = {32'd0, flt.bits};
      end
      default: begin
        ok_raw  = 1'b0;
        res_raw = 64'd0;
      end
    endcase
  end

  assign ok          = ok_raw;
  assign result_bits = ok_raw ? res_raw : 64'd0;

endmodule

FILE: sv/checked_numeric_coercion_top.sv
// ----------------------------------------------------------------------------
// checked_numeric_coercion_top
// A request is held in the input register, its result in the result register.
// Throughput: one request per cycle while rsp.ready is high; an input register
// and a result register let a new request enter while a result waits.
// Reset: synchronous active-high rst empties both stages.
// ----------------------------------------------------------------------------
module checked_numeric_coercion_top (
  input  logic       clk,
  input  logic       rst,
  cnc_req_if.sink    req,
  cnc_rsp_if.source  rsp
);

  logic                      v1;
  logic [cnc_pkg::CmdW-1:0]  cmd1;
  logic [cnc_pkg::KindW-1:0] kind1;
  logic [cnc_pkg::DataW-1:0] pay1;
  logic                      v2;
  logic                      ok2;
  logic [cnc_pkg::DataW-1:0] res2;
  logic                      ok_next;
  logic [cnc_pkg::DataW-1:0] res_next;
  logic                      adv2;
  logic                      adv1;

  assign adv2      = v1 && (!v2 || rsp.ready);
  assign req.ready = !v1 || adv2;
  assign adv1      = req.valid && req.ready;

  cnc_conv u_conv (
    .cmd         (cmd1),
    .value_kind  (kind1),
    .payload     (pay1),
    .ok          (ok_next),
    .result_bits (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (req.ready) v1 <= req.valid;
      if (adv2) v2 <= 1'b1;
      else if (rsp.ready) v2 <= 1'b0;
    end
    if (adv1) begin
      cmd1  <= req.cmd;
      kind1 <= req.value_kind;
      pay1  <= req.payload;
    end
    if (adv2) begin
      ok2  <= ok_next;
      res2 <= res_next;
    end
  end

  assign rsp.valid       = v2;
  assign rsp.ok          = ok2;
  assign rsp.result_bits = res2;

endmodule

FILE: sv/cnc_checker.sv
// ----------------------------------------------------------------------------
// cnc_checker
// Port-level checks of the checked numeric coercion block.
// ----------------------------------------------------------------------------
module cnc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      rsp_ok,
  input logic [cnc_pkg::DataW-1:0] rsp_result_bits
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_bits))
    else $error("result dropped while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_result_bits == 64'd0)
    else $error("failed conversion with nonzero result");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request refused without a stalled result");

endmodule

bind checked_numeric_coercion_top cnc_checker u_cnc_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ok          (rsp.ok),
  .rsp_result_bits (rsp.result_bits)
);
